// ----- hdl/gbn_pkg.sv -----
// gbn_pkg: command and result codes, limits and register indexes
// for the go-back-n sender window control; no dependencies
package gbn_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_FIN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;

  localparam logic [6:0]  MAX_WINDOW      = 7'd64;
  localparam logic [31:0] FIRST_ACK       = 32'd3;
  localparam logic [6:0]  RST_WINDOW_SIZE = 7'd1;
  localparam logic [7:0]  RST_TIMEOUT     = 8'd2;
  localparam logic [3:0]  RST_RETRY_LIMIT = 4'd5;
  localparam logic [3:0]  RETRY_SAT       = 4'd15;

endpackage

// ----- hdl/gbn_in_if.sv -----
// gbn_in_if: input command channel (valid/ready) of the sender control
// depends on gbn_pkg
interface gbn_in_if;
  logic             valid;
  logic             ready;
  gbn_pkg::cmd_t    cmd;
  logic [15:0]      packet_count;
  logic [31:0]      ack_number;

  modport source (output valid, output cmd, output packet_count, output ack_number,
                  input ready);
  modport sink   (input valid, input cmd, input packet_count, input ack_number,
                  output ready);
endinterface

// ----- hdl/gbn_out_if.sv -----
// gbn_out_if: result channel (valid/ready) of the sender control
// depends on gbn_pkg
interface gbn_out_if;
  logic             valid;
  logic             ready;
  gbn_pkg::kind_t   kind;
  logic [15:0]      packet_index;
  logic             is_last_packet;
  logic             last_of_run;

  modport source (output valid, output kind, output packet_index, output is_last_packet,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input packet_index, input is_last_packet,
                  input last_of_run, output ready);
endinterface

// ----- hdl/gbn_cfg_if.sv -----
// gbn_cfg_if: register write channel (valid/ready, index and data)
// no dependencies
interface gbn_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/go_back_n_sender_control.sv -----
// go_back_n_sender_control: go-back-n sender window sequencer; needs gbn_pkg and the interfaces
// a start or timeout resend goes via S_PREP, an ack via S_ACK, S_MOVE and S_PREP, to S_SEND,
// which gives one packet index per cycle across the window (up to 64) unless the result
// channel stalls, or a single done or none result when nothing is left to send; a plain tick,
// an abort, a fin and idle commands give one result; one command at a time
// reset (rst_n low, synchronous): idle, window 1, timeout 2, retry limit 5
module go_back_n_sender_control (
  input  logic       clk,
  input  logic       rst_n,
  gbn_in_if.sink     in_if,
  gbn_out_if.source  out_if,
  gbn_cfg_if.sink    cfg_if
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ACK    = 6'b000010,
    S_MOVE   = 6'b000100,
    S_PREP   = 6'b001000,
    S_SEND   = 6'b010000,
    S_SINGLE = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  logic [6:0]     win_cfg_r;
  logic [7:0]     tmo_cfg_r;
  logic [3:0]     rlim_cfg_r;

  logic           active_r, active_nxt;
  logic [15:0]    total_r, total_nxt;
  logic [16:0]    ws_r, ws_nxt;
  logic [16:0]    nu_r, nu_nxt;
  logic [31:0]    ha_r, ha_nxt;
  logic [7:0]     el_r, el_nxt;
  logic [3:0]     tc_r, tc_nxt;

  logic [16:0]    idx_r, idx_nxt;
  logic [16:0]    end_r, end_nxt;
  logic           resend_r, resend_nxt;
  logic [31:0]    ack_r, ack_nxt;
  logic [30:0]    half_r, half_nxt;
  logic           upd_r, upd_nxt;
  gbn_pkg::kind_t kind_r, kind_nxt;

  logic           out_valid_r, out_valid_nxt;
  gbn_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [15:0]    out_idx_r, out_idx_nxt;
  logic           out_lastpkt_r, out_lastpkt_nxt;
  logic           out_lastrun_r, out_lastrun_nxt;

  logic           in_acc;
  logic           out_free;
  logic [8:0]     tick_e;
  logic [3:0]     tc_sat;
  logic [6:0]     win_eff;
  logic [16:0]    win_end;
  logic [16:0]    pass_end;
  logic [16:0]    pass_first;
  logic [16:0]    total_ext;
  logic [16:0]    room;
  logic [31:0]    ack_diff;
  logic [16:0]    idx_inc;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_kind_r;
  assign out_if.packet_index   = out_idx_r;
  assign out_if.is_last_packet = out_lastpkt_r;
  assign out_if.last_of_run    = out_lastrun_r;

  assign total_ext = {1'b0, total_r};
  assign tick_e    = {1'b0, el_r} + 9'd1;
  assign tc_sat    = (tc_r == gbn_pkg::RETRY_SAT) ? tc_r : tc_r + 4'd1;
  assign win_eff   = (win_cfg_r == 7'd0) ? 7'd1 :
                     (win_cfg_r > gbn_pkg::MAX_WINDOW) ? gbn_pkg::MAX_WINDOW : win_cfg_r;
  assign win_end   = ws_r + {10'd0, win_eff};
  assign pass_end  = (win_end < total_ext) ? win_end : total_ext;
  assign pass_first = resend_r ? ws_r : ((nu_r > ws_r) ? nu_r : ws_r);
  assign room      = total_ext - ws_r;
  assign ack_diff  = ack_r - ha_r;
  assign idx_inc   = idx_r + 17'd1;

  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    total_nxt       = total_r;
    ws_nxt          = ws_r;
    nu_nxt          = nu_r;
    ha_nxt          = ha_r;
    el_nxt          = el_r;
    tc_nxt          = tc_r;
    idx_nxt         = idx_r;
    end_nxt         = end_r;
    resend_nxt      = resend_r;
    ack_nxt         = ack_r;
    half_nxt        = half_r;
    upd_nxt         = upd_r;
    kind_nxt        = kind_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_kind_nxt    = out_kind_r;
    out_idx_nxt     = out_idx_r;
    out_lastpkt_nxt = out_lastpkt_r;
    out_lastrun_nxt = out_lastrun_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_if.cmd == gbn_pkg::CMD_START) begin
            active_nxt = 1'b1;
            total_nxt  = (in_if.packet_count == 16'd0) ? 16'd1 : in_if.packet_count;
            ws_nxt     = 17'd0;
            nu_nxt     = 17'd0;
            ha_nxt     = gbn_pkg::FIRST_ACK;
            tc_nxt     = 4'd0;
            resend_nxt = 1'b0;
            state_nxt  = S_PREP;
          end else if (!active_r) begin
            kind_nxt  = gbn_pkg::KIND_NONE;
            state_nxt = S_SINGLE;
          end else if (in_if.cmd == gbn_pkg::CMD_TICK) begin
            if (tick_e > {1'b0, tmo_cfg_r}) begin
              if (tc_sat >= rlim_cfg_r) begin
                // retries used up
                active_nxt = 1'b0;
                tc_nxt     = 4'd0;
                el_nxt     = 8'd0;
                kind_nxt   = gbn_pkg::KIND_ABORT;
                state_nxt  = S_SINGLE;
              end else begin
                tc_nxt     = tc_sat;
                resend_nxt = 1'b1;
                state_nxt  = S_PREP;
              end
            end else begin
              el_nxt    = tick_e[7:0];
              kind_nxt  = gbn_pkg::KIND_NONE;
              state_nxt = S_SINGLE;
            end
          end else if (in_if.cmd == gbn_pkg::CMD_ACK) begin
            ack_nxt    = in_if.ack_number;
            resend_nxt = 1'b0;
            state_nxt  = S_ACK;
          end else begin
            active_nxt = 1'b0;
            tc_nxt     = 4'd0;
            el_nxt     = 8'd0;
            kind_nxt   = gbn_pkg::KIND_DONE;
            state_nxt  = S_SINGLE;
          end
        end
      end
      S_ACK: begin
        // sequence numbers step by two
        upd_nxt  = ack_r > ha_r;
        half_nxt = ack_diff[31:1];
        if (ack_r > ha_r) begin
          ha_nxt = ack_r;
        end
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        if (upd_r) begin
          tc_nxt = 4'd0;
          if (half_r >= {14'd0, room}) begin
            ws_nxt = total_ext;
          end else begin
            ws_nxt = ws_r + half_r[16:0];
          end
        end
        state_nxt = S_PREP;
      end
      S_PREP: begin
        el_nxt  = 8'd0;
        idx_nxt = pass_first;
        end_nxt = pass_end;
        if (ws_r >= total_ext) begin
          active_nxt = 1'b0;
          tc_nxt     = 4'd0;
          kind_nxt   = gbn_pkg::KIND_DONE;
          state_nxt  = S_SINGLE;
        end else if (pass_first >= pass_end) begin
          kind_nxt  = gbn_pkg::KIND_NONE;
          state_nxt = S_SINGLE;
        end else begin
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = gbn_pkg::KIND_SEND;
          out_idx_nxt     = idx_r[15:0];
          out_lastpkt_nxt = (idx_inc == total_ext);
          out_lastrun_nxt = (idx_inc == end_r);
          nu_nxt          = idx_inc;
          idx_nxt         = idx_inc;
          if (idx_inc == end_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = kind_r;
          out_idx_nxt     = 16'd0;
          out_lastpkt_nxt = 1'b0;
          out_lastrun_nxt = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      total_r     <= 16'd0;
      ws_r        <= 17'd0;
      nu_r        <= 17'd0;
      ha_r        <= gbn_pkg::FIRST_ACK;
      el_r        <= 8'd0;
      tc_r        <= 4'd0;
      out_valid_r <= 1'b0;
      win_cfg_r   <= gbn_pkg::RST_WINDOW_SIZE;
      tmo_cfg_r   <= gbn_pkg::RST_TIMEOUT;
      rlim_cfg_r  <= gbn_pkg::RST_RETRY_LIMIT;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      total_r     <= total_nxt;
      ws_r        <= ws_nxt;
      nu_r        <= nu_nxt;
      ha_r        <= ha_nxt;
      el_r        <= el_nxt;
      tc_r        <= tc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          gbn_pkg::REG_WINDOW_SIZE:   win_cfg_r  <= cfg_if.data[6:0];
          gbn_pkg::REG_TIMEOUT_TICKS: tmo_cfg_r  <= cfg_if.data;
          gbn_pkg::REG_RETRY_LIMIT:   rlim_cfg_r <= cfg_if.data[3:0];
          default: ;
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    end_r         <= end_nxt;
    resend_r      <= resend_nxt;
    ack_r         <= ack_nxt;
    half_r        <= half_nxt;
    upd_r         <= upd_nxt;
    kind_r        <= kind_nxt;
    out_kind_r    <= out_kind_nxt;
    out_idx_r     <= out_idx_nxt;
    out_lastpkt_r <= out_lastpkt_nxt;
    out_lastrun_r <= out_lastrun_nxt;
  end

  // a stalled result holds its payload until taken
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r &&
      $stable({out_kind_r, out_idx_r, out_lastpkt_r, out_lastrun_r}))
    else $error("result changed while stalled");

  // between commands a running transfer has its window start below the count
  a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && active_r |-> ws_r < total_ext)
    else $error("active transfer with closed window");

  // only a send result may flag the final packet
  a_last_pkt_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lastpkt_r |-> out_kind_r == gbn_pkg::KIND_SEND)
    else $error("last packet flag on non-send result");

  // a command transaction always holds the input off in the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready)
    else $error("input ready right after a command");

endmodule

// ----- verif/go_back_n_sender_control_tb.sv -----
// go_back_n_sender_control_tb: self-checking bench for the go-back-n sender window control
// directed table then random transfers; every result transaction is predicted and checked
// depends on gbn_pkg, gbn_in_if, gbn_out_if, gbn_cfg_if and go_back_n_sender_control
module go_back_n_sender_control_tb;

  localparam int unsigned CYCLE_LIMIT      = 3_000_000;
  localparam int          SETTLE_CYCLES    = 80;
  localparam int          SHOWN_MISMATCHES = 10;
  localparam int          N_PHASES         = 12;
  localparam int          LONG_WAIT_PHASE  = 5;

  typedef struct packed {
    gbn_pkg::kind_t kind;
    logic [15:0]    pkt_index;
    logic           last_pkt;
    logic           last_run;
  } window_result_t;

  typedef struct packed {
    logic           is_reg;
    gbn_pkg::cmd_t  cmd;
    logic [15:0]    count;
    logic [31:0]    ack;
    logic [1:0]     reg_idx;
    logic [7:0]     reg_val;
    logic           typed;
    gbn_pkg::kind_t want_kind;
    logic [15:0]    want_index;
    logic           want_last;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  gbn_in_if  in_if();
  gbn_out_if out_if();
  gbn_cfg_if cfg_if();

  go_back_n_sender_control dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #5 clk = ~clk;

  // directed part: idle commands, start/tick/ack/fin, extremes and corner settings
  step_t script [34] = '{
    '{1'b0, gbn_pkg::CMD_TICK,  16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_ACK,   16'd0,    32'hFFFF_FFFF, gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_FIN,   16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    // zero count acts as one packet
    '{1'b0, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b1},
    '{1'b0, gbn_pkg::CMD_TICK,  16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_TICK,  16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_TICK,  16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b1},
    '{1'b0, gbn_pkg::CMD_ACK,   16'd0,    32'd3,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_ACK,   16'd0,    32'd5,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_DONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_START, 16'hFFFF, 32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b0},
    // huge ack jump saturates the window start
    '{1'b0, gbn_pkg::CMD_ACK,   16'd0,    32'hFFFF_FFFF, gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_DONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_START, 16'd3,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_FIN,   16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_DONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_START, 16'd2,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b0},
    // restart while a transfer is running
    '{1'b0, gbn_pkg::CMD_START, 16'd2,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_ACK,   16'd0,    32'd7,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_DONE,  16'd0, 1'b0},
    // zero timeout and zero retry limit: first tick aborts
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_TIMEOUT_TICKS, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_RETRY_LIMIT, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_START, 16'd5,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_TICK,  16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_ABORT, 16'd0, 1'b0},
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_RETRY_LIMIT, 8'd2,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd64,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_START, 16'd100,  32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_TICK,  16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_TICK,  16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_ABORT, 16'd0, 1'b0},
    // zero window acts as one
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_TIMEOUT_TICKS, 8'd1,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_START, 16'd4,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b1, gbn_pkg::KIND_SEND,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_ACK,   16'd0,    32'd9,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    // oversized window acts as the maximum
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'hFF,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_RETRY_LIMIT, 8'hFF,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b1, gbn_pkg::CMD_START, 16'd0,    32'd0,         gbn_pkg::REG_TIMEOUT_TICKS, 8'hFF,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_START, 16'hFFFF, 32'd0,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0},
    '{1'b0, gbn_pkg::CMD_ACK,   16'd0,    32'd5,         gbn_pkg::REG_WINDOW_SIZE, 8'd0,
      1'b0, gbn_pkg::KIND_NONE,  16'd0, 1'b0}
  };

  // window control model
  logic [6:0]  win_reg;
  logic [7:0]  tmo_reg;
  logic [3:0]  retry_reg;
  logic        xfer_on;
  logic [15:0] pkt_total;
  logic [16:0] win_base;
  logic [16:0] next_new;
  logic [31:0] ack_high;
  logic [7:0]  tick_count;
  logic [3:0]  timeouts;

  window_result_t step_results [$];
  window_result_t awaited_results [$];
  window_result_t head;

  int unsigned bad_count = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          gaps_on;
  bit          stalls_on;

  function automatic void note(input gbn_pkg::kind_t k);
    step_results.push_back('{k, 16'd0, 1'b0, 1'b0});
  endfunction

  function automatic void stop_transfer(input gbn_pkg::kind_t k);
    xfer_on = 1'b0;
    timeouts = '0;
    tick_count = '0;
    note(k);
  endfunction

  function automatic void send_window(input bit resend_all);
    int unsigned span;
    int unsigned i;
    span = win_reg;
    if (span == 0) span = 1;
    if (span > gbn_pkg::MAX_WINDOW) span = gbn_pkg::MAX_WINDOW;
    tick_count = '0;
    for (i = win_base; i < win_base + span && i < pkt_total; i++) begin
      if (i >= next_new || resend_all) begin
        step_results.push_back('{gbn_pkg::KIND_SEND, 16'(i), (i + 1 == pkt_total), 1'b0});
        next_new = 17'(i + 1);
      end
    end
  endfunction

  function automatic void compute_results(input gbn_pkg::cmd_t c, input logic [15:0] cnt,
                                          input logic [31:0] ack);
    int unsigned     step_ticks;
    longint unsigned base;
    step_results.delete();
    if (c == gbn_pkg::CMD_START) begin
      xfer_on = 1'b1;
      pkt_total = (cnt == 16'd0) ? 16'd1 : cnt;
      win_base = '0;
      next_new = '0;
      ack_high = gbn_pkg::FIRST_ACK;
      timeouts = '0;
      send_window(1'b0);
    end else if (!xfer_on) begin
      note(gbn_pkg::KIND_NONE);
    end else begin
      case (c)
        gbn_pkg::CMD_TICK: begin
          step_ticks = tick_count + 1;
          if (step_ticks > tmo_reg) begin
            if (timeouts < gbn_pkg::RETRY_SAT) timeouts = timeouts + 4'd1;
            if (timeouts >= retry_reg) stop_transfer(gbn_pkg::KIND_ABORT);
            else send_window(1'b1);
          end else begin
            tick_count = (step_ticks > 255) ? 8'd255 : 8'(step_ticks);
          end
        end
        gbn_pkg::CMD_ACK: begin
          if (ack > ack_high) begin
            // sequence numbers advance by two per packet
            base = win_base + ((ack - ack_high) >> 1);
            if (base > pkt_total) base = pkt_total;
            win_base = 17'(base);
            ack_high = ack;
            timeouts = '0;
          end
          if (win_base >= pkt_total) stop_transfer(gbn_pkg::KIND_DONE);
          else send_window(1'b0);
        end
        default: stop_transfer(gbn_pkg::KIND_DONE);
      endcase
    end
    if (step_results.size() == 0) note(gbn_pkg::KIND_NONE);
    step_results[step_results.size() - 1].last_run = 1'b1;
  endfunction

  function automatic void report_bad(input string msg);
    bad_count++;
    if (bad_count <= SHOWN_MISMATCHES) $display("mismatch at cycle %0d: %s", cycles, msg);
  endfunction

  function automatic step_t random_step();
    step_t       s;
    int unsigned r;
    s = '0;
    r = $urandom_range(0, 99);
    s.count = 16'($urandom_range(1, 40));
    s.ack = ack_high + 32'($urandom_range(0, 40));
    if ((!xfer_on && r < 85) || r < 4) begin
      s.cmd = gbn_pkg::CMD_START;
      case ($urandom_range(0, 19))
        0:       s.count = 16'hFFFF;
        1:       s.count = 16'h0000;
        2, 3:    s.count = 16'($urandom);
        default: ;
      endcase
    end else if (r < 50) begin
      s.cmd = gbn_pkg::CMD_ACK;
    end else if (r < 78) begin
      s.cmd = gbn_pkg::CMD_TICK;
    end else if (r < 82) begin
      s.cmd = gbn_pkg::CMD_FIN;
    end else begin
      // noise: any command, arbitrary count, stale or wild ack numbers
      s.cmd = gbn_pkg::cmd_t'($urandom_range(0, 3));
      s.count = 16'($urandom);
      s.ack = $urandom;
    end
    return s;
  endfunction

  task automatic wait_all_seen();
    in_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    wait_all_seen();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      gbn_pkg::REG_WINDOW_SIZE:   win_reg = val[6:0];
      gbn_pkg::REG_TIMEOUT_TICKS: tmo_reg = val;
      gbn_pkg::REG_RETRY_LIMIT:   retry_reg = val[3:0];
      default: ;
    endcase
  endtask

  // valid stays high between back-to-back transactions, lowered for a gap or by wait_all_seen
  task automatic issue(input step_t s);
    int unsigned i;
    cfg_if.valid <= 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= s.cmd;
    in_if.packet_count <= s.count;
    in_if.ack_number   <= s.ack;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    compute_results(s.cmd, s.count, s.ack);
    if (s.typed) begin
      step_results.delete();
      step_results.push_back('{s.want_kind, s.want_index, s.want_last, 1'b1});
    end
    for (i = 0; i < step_results.size(); i++) awaited_results.push_back(step_results[i]);
  endtask

  // result sink with random back-pressure bursts
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= (hold_left == 1);
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(1, 9);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        report_bad($sformatf("unexpected result kind %0d index %0d last_pkt %0d last_run %0d",
                             out_if.kind, out_if.packet_index, out_if.is_last_packet,
                             out_if.last_of_run));
      end else begin
        head = awaited_results.pop_front();
        if (out_if.kind !== head.kind || out_if.packet_index !== head.pkt_index ||
            out_if.is_last_packet !== head.last_pkt || out_if.last_of_run !== head.last_run)
          report_bad($sformatf({"expected kind %0d index %0d last_pkt %0d last_run %0d, ",
                                "got kind %0d index %0d last_pkt %0d last_run %0d"},
                               head.kind, head.pkt_index, head.last_pkt, head.last_run,
                               out_if.kind, out_if.packet_index, out_if.is_last_packet,
                               out_if.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    step_t       s;
    int unsigned p;
    int unsigned phase_len;
    logic [7:0]  val;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = gbn_pkg::CMD_START;
    in_if.packet_count = '0;
    in_if.ack_number = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = gbn_pkg::REG_WINDOW_SIZE;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    win_reg = gbn_pkg::RST_WINDOW_SIZE;
    tmo_reg = gbn_pkg::RST_TIMEOUT;
    retry_reg = gbn_pkg::RST_RETRY_LIMIT;
    xfer_on = 1'b0;
    pkt_total = '0;
    win_base = '0;
    next_new = '0;
    ack_high = gbn_pkg::FIRST_ACK;
    tick_count = '0;
    timeouts = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[n]) begin
      if (script[n].is_reg) write_reg(script[n].reg_idx, script[n].reg_val);
      else issue(script[n]);
    end

    for (p = 0; p < N_PHASES; p++) begin
      // the last phase runs with no gaps and no back-pressure
      gaps_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);

      case ($urandom_range(0, 7))
        0:       val = 8'd0;
        1:       val = 8'($urandom_range(65, 255));
        2:       val = 8'd64;
        default: val = 8'($urandom_range(1, 16));
      endcase
      write_reg(gbn_pkg::REG_WINDOW_SIZE, val);
      case ($urandom_range(0, 5))
        0:       val = 8'd0;
        1:       val = 8'd255;
        default: val = 8'($urandom_range(1, 4));
      endcase
      if (p == LONG_WAIT_PHASE) val = 8'd255;
      write_reg(gbn_pkg::REG_TIMEOUT_TICKS, val);
      case ($urandom_range(0, 5))
        0:       val[3:0] = 4'd0;
        1:       val[3:0] = 4'd15;
        default: val[3:0] = 4'($urandom_range(1, 6));
      endcase
      val[7:4] = 4'($urandom);
      write_reg(gbn_pkg::REG_RETRY_LIMIT, val);

      if (p == LONG_WAIT_PHASE) begin
        // elapsed count saturates, only the tick reaching 256 times out
        s = '0;
        s.cmd = gbn_pkg::CMD_START;
        s.count = 16'd20;
        issue(s);
        s.cmd = gbn_pkg::CMD_TICK;
        repeat (257) issue(s);
        s.cmd = gbn_pkg::CMD_ACK;
        s.ack = ack_high + 32'd6;
        issue(s);
      end else begin
        phase_len = $urandom_range(14, 20);
        repeat (phase_len) issue(random_step());
      end
    end

    wait_all_seen();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
